// File: hdl/nrmc_pkg.sv
// Package for the RMC sentence parser: sizes, character codes, arithmetic constants.
// Shared by the parser top level, its checker and the testbench. No dependencies.
`default_nettype none
package nrmc_pkg;

  localparam int BUFFER_BYTES = 128;
  localparam int FIELD_CHARS  = 15;

  localparam int CNT_W  = $clog2(BUFFER_BYTES);
  localparam int TCH_W  = $clog2(FIELD_CHARS + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam logic [16:0] INT_PART_MAX = 17'd99999;
  localparam logic [3:0]  PH_INT       = 4'd0;
  localparam logic [3:0]  PH_FRAC_END  = 4'd5;
  localparam logic [3:0]  PH_DONE      = 4'd15;

  // floor(x/100) = (x*167773)>>24 for x < 199728
  localparam logic [17:0] DIV100_MUL = 18'd167773;
  // floor(x/3) = (x*2796203)>>23 for x < 2^23
  localparam logic [21:0] DIV3_MUL   = 22'd2796203;

  localparam logic [30:0] POS_LIMIT  = 31'd1001000000;

  typedef struct packed {
    logic [2:0][7:0]  tm;
    logic             fix;
    logic             upd;
    logic [1:0][16:0] ip;
    logic [1:0][13:0] frac;
    logic [1:0]       neg;
  } snap_t;

  function automatic logic [13:0] frac_weight(input logic [3:0] ph);
    logic [13:0] w;
    case (ph)
      4'd1:    w = 14'd1000;
      4'd2:    w = 14'd100;
      4'd3:    w = 14'd10;
      4'd4:    w = 14'd1;
      default: w = 14'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: hdl/nmea_rmc_sentence_parser_top.sv
// RMC sentence parser: byte-wise parser state plus a five-stage coordinate pipeline.
// Depends on nrmc_pkg.
//
// Throughput: one byte per cycle unless in_stall_o is high; a '*' byte enters the
//   pipeline in the cycle it is taken. A result for a '*' transfer passes the snapshot
//   register, four stages for the divide-by-100 and divide-by-3 reciprocal multiplies
//   and the output register, and is held back while the output stalls.
// Reset: asynchronous, active low; clears parser state, held time/fix/position and all
//   pipeline valid bits.
`default_nettype none
module nmea_rmc_sentence_parser_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              hour_o,
  output logic [7:0]              minute_o,
  output logic [7:0]              second_o,
  output logic                    fix_valid_o,
  output logic signed [30:0]      latitude_udeg_o,
  output logic signed [30:0]      longitude_udeg_o,
  output logic                    position_updated_o
);
  import nrmc_pkg::*;

  // ---------------------------------------------------------------------------
  // Parser state (per sentence, cleared by '$')
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              first_q, first_d;
  logic              second_q, second_d;
  logic              stk_q, stk_d;        // status character taken
  logic [2:0]        tpos_q, tpos_d;
  logic [5:0][7:0]   tch_q, tch_d;
  logic [7:0]        stat_q, stat_d;
  logic [7:0]        tok_q, tok_d;
  logic [TCH_W-1:0]  tcnt_q, tcnt_d;      // chars in current token, saturates at FIELD_CHARS
  logic              pwc_q, pwc_d;        // previous byte was a comma
  logic [1:0][7:0]   win_q, win_d;
  logic              tf_q, tf_d;          // "RMC" seen
  logic [1:0][16:0]  ci_q, ci_d;
  logic [1:0][13:0]  cf_q, cf_d;
  logic [1:0][3:0]   ph_q, ph_d;
  logic [1:0][7:0]   hemi_q, hemi_d;

  // Held across sentences
  logic [2:0][7:0]   htm_q, htm_d;
  logic              hfix_q, hfix_d;
  logic [1:0][30:0]  hpos_q;

  // Pipeline
  logic              v1_q, v2_q, v3_q, v4_q, v5_q, out_v_q;
  logic              free1, free2, free3, free4, free5, free6;
  logic              accept, star;

  snap_t             s1_q, s1_d;
  snap_t             s2_q, s3_q, s4_q, s5_q;
  logic [1:0][9:0]   deg2_q, deg3_q;
  logic [1:0][6:0]   rem3_q;
  logic [1:0][19:0]  m4_q;
  logic [1:0][29:0]  dm4_q, dm5_q;
  logic [1:0][20:0]  t5_q;

  logic [1:0][9:0]   deg2_d;
  logic [1:0][6:0]   rem3_d;
  logic [1:0][19:0]  m4_d;
  logic [1:0][29:0]  dm4_d;
  logic [1:0][20:0]  t5_d;
  logic [1:0][30:0]  pos_new, pos_sel;

  // Each stage loads when it is empty or its contents move on.
  assign free6  = !out_v_q || !out_stall_i;
  assign free5  = !v5_q || free6;
  assign free4  = !v4_q || free5;
  assign free3  = !v3_q || free4;
  assign free2  = !v2_q || free3;
  assign free1  = !v1_q || free2;

  assign in_stall_o = !free1;
  assign accept     = in_valid_i && !in_stall_o;
  assign star       = accept && (rx_byte_i == CH_STAR);

  // ---------------------------------------------------------------------------
  // Byte parser: next state of every per-sentence register for this byte.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [7:0]  b;
    logic        dig;
    logic [3:0]  dv;
    logic [20:0] iv;
    logic [1:0]  sel;
    logic [7:0]  tv;
    b  = rx_byte_i;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    dv  = b[3:0];
    iv  = '0;
    sel = '0;
    tv  = '0;

    cnt_d = cnt_q;  first_d = first_q; second_d = second_q; stk_d = stk_q;
    tpos_d = tpos_q; tch_d = tch_q; stat_d = stat_q; tok_d = tok_q;
    tcnt_d = tcnt_q; pwc_d = pwc_q; win_d = win_q; tf_d = tf_q;
    ci_d = ci_q; cf_d = cf_q; ph_d = ph_q; hemi_d = hemi_q;
    htm_d = htm_q; hfix_d = hfix_q;

    if (accept) begin
      if (b == CH_DOLLAR) begin
        cnt_d = '0; first_d = 1'b0; second_d = 1'b0; stk_d = 1'b0;
        tpos_d = '0; tch_d = '0; stat_d = '0; tok_d = '0; tcnt_d = '0;
        pwc_d = 1'b1; win_d = '0; tf_d = 1'b0;
        ci_d = '0; cf_d = '0; ph_d = {PH_INT, PH_INT}; hemi_d = '0;
      end

      if (cnt_d < CNT_W'(BUFFER_BYTES - 1)) begin
        if (second_d && !stk_d) begin
          stat_d = b;
          stk_d  = 1'b1;
        end
        if (first_d && (tpos_d < 3'd6)) begin
          tch_d[tpos_d] = b;
          tpos_d        = tpos_d + 3'd1;
        end
        if (b == CH_COMMA) begin
          if (!first_d) first_d = 1'b1;
          else if (!second_d) second_d = 1'b1;
        end

        if ((win_d[0] == CH_R) && (win_d[1] == CH_M) && (b == CH_C)) tf_d = 1'b1;
        win_d[0] = win_d[1];
        win_d[1] = b;

        if (b == CH_COMMA) begin
          pwc_d = 1'b1;
        end else begin
          if (pwc_d) begin
            if (tok_d != 8'd255) tok_d = tok_d + 8'd1;
            tcnt_d = '0;
          end
          pwc_d = 1'b0;
          sel[0] = (tok_d == 8'd4) && (tcnt_d < TCH_W'(FIELD_CHARS));
          sel[1] = (tok_d == 8'd6) && (tcnt_d < TCH_W'(FIELD_CHARS));
          for (int k = 0; k < 2; k++) begin
            if (sel[k]) begin
              if (ph_d[k] == PH_INT) begin
                if (dig) begin
                  iv = 21'(ci_d[k]) * 21'd10 + 21'(dv);
                  ci_d[k] = (iv > 21'(INT_PART_MAX)) ? INT_PART_MAX : iv[16:0];
                end else if (b == CH_DOT) begin
                  ph_d[k] = 4'd1;
                end else begin
                  ph_d[k] = PH_DONE;
                end
              end else if (ph_d[k] <= PH_FRAC_END) begin
                if (dig) begin
                  if (ph_d[k] < PH_FRAC_END) begin
                    cf_d[k] = cf_d[k] + 14'(dv) * frac_weight(ph_d[k]);
                    ph_d[k] = ph_d[k] + 4'd1;
                  end
                end else begin
                  ph_d[k] = PH_DONE;
                end
              end
            end
          end
          if (tcnt_d == '0) begin
            if (tok_d == 8'd5) hemi_d[0] = b;
            else if (tok_d == 8'd7) hemi_d[1] = b;
          end
          if (tcnt_d != TCH_W'(FIELD_CHARS)) tcnt_d = tcnt_d + TCH_W'(1);
        end
        cnt_d = cnt_d + CNT_W'(1);
      end

      // Result on '*': refresh held time and fix from the updated state.
      if (b == CH_STAR && first_d) begin
        if (tpos_d >= 3'd6) begin
          for (int k = 0; k < 3; k++) begin
            tv = tch_d[2*k] * 8'd10;
            htm_d[k] = tv + tch_d[2*k+1] - 8'd16;
          end
        end
        if (second_d && stk_d && ((stat_d == CH_A) || (stat_d == CH_V)))
          hfix_d = (stat_d == CH_A);
      end
    end
  end

  // Snapshot taken into the pipeline with a '*' transfer
  always_comb begin
    s1_d.tm   = htm_d;
    s1_d.fix  = hfix_d;
    s1_d.upd  = hfix_d && tf_d;
    s1_d.ip   = ci_d;
    s1_d.frac = cf_d;
    s1_d.neg  = {hemi_d[1] == CH_W, hemi_d[0] == CH_S};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; first_q <= 1'b0; second_q <= 1'b0; stk_q <= 1'b0;
      tpos_q <= '0; tch_q <= '0; stat_q <= '0; tok_q <= '0; tcnt_q <= '0;
      pwc_q <= 1'b1; win_q <= '0; tf_q <= 1'b0;
      ci_q <= '0; cf_q <= '0; ph_q <= {PH_INT, PH_INT}; hemi_q <= '0;
      htm_q <= '0; hfix_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; first_q <= first_d; second_q <= second_d; stk_q <= stk_d;
      tpos_q <= tpos_d; tch_q <= tch_d; stat_q <= stat_d; tok_q <= tok_d;
      tcnt_q <= tcnt_d; pwc_q <= pwc_d; win_q <= win_d; tf_q <= tf_d;
      ci_q <= ci_d; cf_q <= cf_d; ph_q <= ph_d; hemi_q <= hemi_d;
      htm_q <= htm_d; hfix_q <= hfix_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Coordinate pipeline
  //   stage 2: degrees = integer part / 100 (reciprocal multiply)
  //   stage 3: minutes integer = integer part - 100 * degrees
  //   stage 4: minutes in 1e-4 units; degrees * 1e6
  //   stage 5: minutes * 5 / 3 (reciprocal multiply)
  //   output : add, apply hemisphere sign, update held position
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [34:0] p100;
    logic [16:0] r17;
    logic [22:0] q5;
    logic [44:0] p3;
    logic [30:0] sum;
    for (int k = 0; k < 2; k++) begin
      p100      = 35'(s1_q.ip[k]) * 35'(DIV100_MUL);
      deg2_d[k] = p100[33:24];
      r17       = s2_q.ip[k] - (17'(deg2_q[k]) * 17'd100);
      rem3_d[k] = r17[6:0];
      m4_d[k]   = 20'(rem3_q[k]) * 20'd10000 + 20'(s3_q.frac[k]);
      dm4_d[k]  = 30'(deg3_q[k]) * 30'd1000000;
      q5        = {m4_q[k], 2'b00} + 23'(m4_q[k]);
      p3        = 45'(q5) * 45'(DIV3_MUL);
      t5_d[k]   = p3[43:23];
      sum       = 31'(dm5_q[k]) + 31'(t5_q[k]);
      pos_new[k] = s5_q.neg[k] ? (31'd0 - sum) : sum;
      pos_sel[k] = s5_q.upd ? pos_new[k] : hpos_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      out_v_q <= 1'b0;
      hpos_q <= '0;
    end else begin
      if (free1) v1_q <= star;
      if (free2) v2_q <= v1_q;
      if (free3) v3_q <= v2_q;
      if (free4) v4_q <= v3_q;
      if (free5) v5_q <= v4_q;
      if (free6) begin
        out_v_q <= v5_q;
        if (v5_q) hpos_q <= pos_sel;
      end
    end
  end

  // Payload registers: load when the stage loads
  always_ff @(posedge clk_i) begin
    if (free1) s1_q <= s1_d;
    if (free2) begin
      s2_q <= s1_q; deg2_q <= deg2_d;
    end
    if (free3) begin
      s3_q <= s2_q; deg3_q <= deg2_q; rem3_q <= rem3_d;
    end
    if (free4) begin
      s4_q <= s3_q; m4_q <= m4_d; dm4_q <= dm4_d;
    end
    if (free5) begin
      s5_q <= s4_q; dm5_q <= dm4_q; t5_q <= t5_d;
    end
    if (free6 && v5_q) begin
      hour_o             <= s5_q.tm[0];
      minute_o           <= s5_q.tm[1];
      second_o           <= s5_q.tm[2];
      fix_valid_o        <= s5_q.fix;
      position_updated_o <= s5_q.upd;
      latitude_udeg_o    <= pos_sel[0];
      longitude_udeg_o   <= pos_sel[1];
    end
  end

  assign out_valid_o = out_v_q;

endmodule
`default_nettype wire

// File: hdl/nrmc_checker.sv
// Port-level checker for the RMC sentence parser, bound to the top level.
// Depends on nrmc_pkg.
`default_nettype none
module nrmc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [7:0]         hour_o,
  input wire logic               fix_valid_o,
  input wire logic signed [30:0] latitude_udeg_o,
  input wire logic signed [30:0] longitude_udeg_o,
  input wire logic               position_updated_o
);
  import nrmc_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hour_o)
      && $stable(latitude_udeg_o))
    else $error("stalled result changed");

  // A refreshed position implies a valid fix.
  a_upd_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && position_updated_o |-> fix_valid_o)
    else $error("position updated without fix");

  // Positions stay within the converted range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (latitude_udeg_o <= $signed(POS_LIMIT))
      && (latitude_udeg_o >= -$signed(POS_LIMIT))
      && (longitude_udeg_o <= $signed(POS_LIMIT))
      && (longitude_udeg_o >= -$signed(POS_LIMIT)))
    else $error("position out of range");

  // Input is only stalled while a result is pending downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

endmodule

bind nmea_rmc_sentence_parser_top nrmc_checker u_nrmc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .hour_o             (hour_o),
  .fix_valid_o        (fix_valid_o),
  .latitude_udeg_o    (latitude_udeg_o),
  .longitude_udeg_o   (longitude_udeg_o),
  .position_updated_o (position_updated_o)
);
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the RMC sentence parser: directed and random byte streams, checked
// against a behavioral model of the parser held in a scoreboard class.
// Depends on nrmc_pkg and nmea_rmc_sentence_parser_top.
`default_nettype none
module tb_top;
  import nrmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic fix;
    logic signed [30:0] lat;
    logic signed [30:0] lon;
    logic upd;
  } fix_report_t;

  // Sentence parser model; predicts a report for every '*' it is fed.
  class rmc_scoreboard;
    int unsigned stored;
    bit comma1, comma2, status_taken;
    int unsigned tpos;
    logic [7:0] tch[6];
    logic [7:0] status;
    int unsigned tok_num, tok_chars;
    bit prev_comma;
    logic [7:0] win[2];
    bit rmc_seen;
    int unsigned ipart[2], fpart[2], phase[2];
    logic [7:0] hemi[2];
    logic [7:0] htime[3];
    bit hvalid;
    logic signed [31:0] hpos[2];
    fix_report_t pending[$];
    int errors;

    function void clear_sentence();
      stored = 0; comma1 = 0; comma2 = 0; status_taken = 0; tpos = 0;
      foreach (tch[k]) tch[k] = 0;
      status = 0; tok_num = 0; tok_chars = 0; prev_comma = 1;
      win[0] = 0; win[1] = 0; rmc_seen = 0;
      for (int k = 0; k < 2; k++) begin
        ipart[k] = 0; fpart[k] = 0; phase[k] = 0; hemi[k] = 0;
      end
    endfunction

    function void reset_all();
      clear_sentence();
      foreach (htime[k]) htime[k] = 0;
      hvalid = 0; hpos[0] = 0; hpos[1] = 0; errors = 0;
      pending.delete();
    endfunction

    function void coord_byte(int k, logic [7:0] b);
      int unsigned ph, v;
      bit dig;
      ph = phase[k];
      dig = (b >= CH_ZERO && b <= CH_NINE);
      if (ph == 0) begin
        if (dig) begin
          v = ipart[k] * 10 + (b - CH_ZERO);
          ipart[k] = (v > INT_PART_MAX) ? INT_PART_MAX : v;
        end else if (b == CH_DOT) ph = 1;
        else ph = PH_DONE;
      end else if (ph <= PH_FRAC_END) begin
        if (dig) begin
          if (ph < PH_FRAC_END) begin
            fpart[k] += (b - CH_ZERO) * (10 ** (4 - ph));
            ph++;
          end
        end else ph = PH_DONE;
      end
      phase[k] = ph;
    endfunction

    function logic signed [31:0] to_udeg(int k, logic [7:0] neg_ch);
      int unsigned m4;
      logic signed [31:0] v;
      m4 = (ipart[k] % 100) * 10000 + fpart[k];
      v = (ipart[k] / 100) * 1000000 + (m4 * 5) / 3;
      return (hemi[k] == neg_ch) ? -v : v;
    endfunction

    function void parse(logic [7:0] b);
      if (comma2 && !status_taken) begin
        status = b; status_taken = 1;
      end
      if (comma1 && tpos < 6) begin
        tch[tpos] = b; tpos++;
      end
      if (b == CH_COMMA) begin
        if (!comma1) comma1 = 1;
        else if (!comma2) comma2 = 1;
      end
      if (win[0] == CH_R && win[1] == CH_M && b == CH_C) rmc_seen = 1;
      win[0] = win[1]; win[1] = b;
      if (b == CH_COMMA) begin
        prev_comma = 1;
        return;
      end
      if (prev_comma) begin
        if (tok_num < 255) tok_num++;
        tok_chars = 0;
      end
      prev_comma = 0;
      if (tok_chars < FIELD_CHARS) begin
        if (tok_num == 4) coord_byte(0, b);
        else if (tok_num == 6) coord_byte(1, b);
      end
      if (tok_chars == 0) begin
        if (tok_num == 5) hemi[0] = b;
        else if (tok_num == 7) hemi[1] = b;
      end
      if (tok_chars < 255) tok_chars++;
    endfunction

    // Note an accepted byte; queue a report when it is a '*'.
    function void note_byte(logic [7:0] b);
      fix_report_t r;
      bit upd;
      upd = 0;
      if (b == CH_DOLLAR) clear_sentence();
      if (stored < BUFFER_BYTES - 1) begin
        parse(b); stored++;
      end
      if (b != CH_STAR) return;
      if (comma1) begin
        if (tpos >= 6)
          for (int k = 0; k < 3; k++)
            htime[k] = 8'(tch[2*k] * 10 + tch[2*k+1] - 528);
        if (comma2 && status_taken && (status == CH_A || status == CH_V))
          hvalid = (status == CH_A);
      end
      if (hvalid && rmc_seen) begin
        hpos[0] = to_udeg(0, CH_S);
        hpos[1] = to_udeg(1, CH_W);
        upd = 1;
      end
      r.hour = htime[0]; r.minute = htime[1]; r.second = htime[2];
      r.fix = hvalid; r.lat = hpos[0][30:0]; r.lon = hpos[1][30:0]; r.upd = upd;
      pending.push_back(r);
    endfunction

    function void check_report(fix_report_t got);
      fix_report_t e;
      if (pending.size() == 0) begin
        $error("report with none expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hour !== e.hour) begin
        $error("hour exp %0d got %0d", e.hour, got.hour); errors++;
      end
      if (got.minute !== e.minute) begin
        $error("minute exp %0d got %0d", e.minute, got.minute); errors++;
      end
      if (got.second !== e.second) begin
        $error("second exp %0d got %0d", e.second, got.second); errors++;
      end
      if (got.fix !== e.fix) begin
        $error("fix_valid exp %0b got %0b", e.fix, got.fix); errors++;
      end
      if (got.lat !== e.lat) begin
        $error("latitude_udeg exp %0d got %0d", e.lat, got.lat); errors++;
      end
      if (got.lon !== e.lon) begin
        $error("longitude_udeg exp %0d got %0d", e.lon, got.lon); errors++;
      end
      if (got.upd !== e.upd) begin
        $error("position_updated exp %0b got %0b", e.upd, got.upd); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [7:0] rx_byte_i = 0;
  logic in_stall_o, out_valid_o, fix_valid_o, position_updated_o;
  logic [7:0] hour_o, minute_o, second_o;
  logic signed [30:0] latitude_udeg_o, longitude_udeg_o;

  nmea_rmc_sentence_parser_top dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  rmc_scoreboard fixes = new();
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;   // receiver hold-off, counted down by its own process
  byte unsigned bytes_q[$];

  // Receiver: drive stall from the idle rate or a long hold-off.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: check every report transferred out.
  always @(posedge clk_i) begin
    fix_report_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.hour = hour_o; got.minute = minute_o; got.second = second_o;
      got.fix = fix_valid_o; got.lat = latitude_udeg_o;
      got.lon = longitude_udeg_o; got.upd = position_updated_o;
      fixes.check_report(got);
    end
  end

  // Send one byte; hold it until the block takes it.
  task automatic send_byte(byte unsigned b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fixes.note_byte(b);
  endtask

  task automatic send_text(string s);
    foreach (s[k]) send_byte(s[k]);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (fixes.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    repeat (n) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  function automatic string field_text();
    case ($urandom_range(9))
      0: return "";
      1: return digits($urandom_range(1, 20));
      2: return {digits($urandom_range(1, 8)), ".", digits($urandom_range(0, 8)), "x9"};
      default: return {digits($urandom_range(3, 5)), ".", digits($urandom_range(0, 6))};
    endcase
  endfunction

  // Build a mostly well-formed RMC sentence with random content and damage.
  function automatic string rmc_sentence();
    string s, st;
    int pick;
    pick = $urandom_range(9);
    st = (pick < 6) ? "A" : (pick < 8) ? "V" : string'(8'($urandom_range(255)));
    s = {"$GP", ($urandom_range(9) < 8) ? "RMC" : "RMB", ",",
         digits($urandom_range(0, 9) < 8 ? 6 : $urandom_range(0, 5)), ",", st, ","};
    s = {s, field_text(), ",", ($urandom_range(1) ? "S" : "N"), ",",
         field_text(), ",", ($urandom_range(1) ? "W" : "E"), ",1.0,2.0*"};
    if ($urandom_range(9) == 0) s = {s, "4F*"};
    return s;
  endfunction

  int sent;

  task automatic random_phase(int n);
    string s;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 8) s = rmc_sentence();
      else begin
        s = "";
        repeat ($urandom_range(1, 30)) s = {s, string'(8'($urandom_range(255)))};
      end
      send_text(s);
      sent += s.len();
    end
  endtask

  initial begin
    string big;
    fixes.reset_all();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset report, short time, status extremes, south/west, saturation.
    send_text("*");
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,*");
    send_text("$GPRMC,99,A,,S,,W*");
    send_text("$GPRMC,000000,V,1.2,S,2.3,W*");
    send_text("$GPRMC,235959,A,999999999.99999,S,99999.1234,W*");
    send_byte(8'h00); send_byte(8'hFF); send_text(",,*");
    drain();

    // Overlong sentence: bytes past the buffer are dropped, '*' still reports.
    big = "$GPRMC,010203,A,1234.5,N,1,E,";
    while (big.len() < 200) big = {big, "7"};
    send_text({big, "*"});
    drain();

    send_idle_pct = 38; recv_idle_pct = 69;
    random_phase(230);
    // Long receiver hold-off while reports keep coming.
    hold_cycles = 300;
    repeat (8) send_text("$GPRMC,111111,A,1,S,2,W*");
    drain();
    send_idle_pct = 69; recv_idle_pct = 38;
    random_phase(230);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(230);
    drain();

    if (fixes.errors == 0 && fixes.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
